// ===== hdl/sc2a_pkg.sv =====
package sc2a_pkg;

  localparam logic       CmdScan    = 1'b0;
  localparam logic       CmdRead    = 1'b1;
  localparam int         ScanW      = 8;
  localparam int         CharW      = 7;
  localparam logic [6:0] KeyLshift  = 7'h2A;
  localparam logic [6:0] KeyRshift  = 7'h36;

  // set-1 make code to ASCII, plain and shifted layers
  function automatic logic [CharW-1:0] key_to_char(input logic shift, input logic [6:0] key);
    logic [7:0] pl;
    logic [7:0] sh;
    pl = 8'h00;
    sh = 8'h00;
    unique case (key)
      7'h01: begin pl = 8'h1B; sh = 8'h1B; end
      7'h02: begin pl = "1";   sh = "!";   end
      7'h03: begin pl = "2";   sh = 8'h22; end
      7'h04: begin pl = "3";   sh = "#";   end
      7'h05: begin pl = "4";   sh = "$";   end
      7'h06: begin pl = "5";   sh = "%";   end
      7'h07: begin pl = "6";   sh = "&";   end
      7'h08: begin pl = "7";   sh = "/";   end
      7'h09: begin pl = "8";   sh = "(";   end
      7'h0A: begin pl = "9";   sh = ")";   end
      7'h0B: begin pl = "0";   sh = "=";   end
      7'h0C: begin pl = "+";   sh = "?";   end
      7'h0D: begin pl = 8'h27; sh = 8'h60; end
      7'h0E: begin pl = 8'h08; sh = 8'h08; end
      7'h0F: begin pl = 8'h09; sh = 8'h09; end
      7'h10: begin pl = "q";   sh = "Q";   end
      7'h11: begin pl = "w";   sh = "W";   end
      7'h12: begin pl = "e";   sh = "E";   end
      7'h13: begin pl = "r";   sh = "R";   end
      7'h14: begin pl = "t";   sh = "T";   end
      7'h15: begin pl = "y";   sh = "Y";   end
      7'h16: begin pl = "u";   sh = "U";   end
      7'h17: begin pl = "i";   sh = "I";   end
      7'h18: begin pl = "o";   sh = "O";   end
      7'h19: begin pl = "p";   sh = "P";   end
      7'h1A: begin pl = "a";   sh = "A";   end
      7'h1B: begin pl = "u";   sh = "U";   end
      7'h1C: begin pl = 8'h0D; sh = 8'h0D; end
      7'h1E: begin pl = "a";   sh = "A";   end
      7'h1F: begin pl = "s";   sh = "S";   end
      7'h20: begin pl = "d";   sh = "D";   end
      7'h21: begin pl = "f";   sh = "F";   end
      7'h22: begin pl = "g";   sh = "G";   end
      7'h23: begin pl = "h";   sh = "H";   end
      7'h24: begin pl = "j";   sh = "J";   end
      7'h25: begin pl = "k";   sh = "K";   end
      7'h26: begin pl = "l";   sh = "L";   end
      7'h27: begin pl = "o";   sh = "O";   end
      7'h28: begin pl = "a";   sh = "A";   end
      7'h29: begin pl = "^";   sh = "*";   end
      7'h2B: begin pl = "<";   sh = ">";   end
      7'h2C: begin pl = "z";   sh = "Z";   end
      7'h2D: begin pl = "x";   sh = "X";   end
      7'h2E: begin pl = "c";   sh = "C";   end
      7'h2F: begin pl = "v";   sh = "V";   end
      7'h30: begin pl = "b";   sh = "B";   end
      7'h31: begin pl = "n";   sh = "N";   end
      7'h32: begin pl = "m";   sh = "M";   end
      7'h33: begin pl = ",";   sh = ";";   end
      7'h34: begin pl = ".";   sh = ":";   end
      7'h35: begin pl = "-";   sh = "_";   end
      7'h39: begin pl = " ";   sh = " ";   end
      default: begin pl = 8'h00; sh = 8'h00; end
    endcase
    return shift ? sh[CharW-1:0] : pl[CharW-1:0];
  endfunction

endpackage

// ===== hdl/sc2a_ram.sv =====
module sc2a_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/scan_code_to_ascii_fifo.sv =====
// channel  | dir | tdata                  | tuser
// s_axis   | in  | [7:0] scan_code        | [0] cmd (0 scan, 1 read)
// m_axis   | out | [6:0] out_char, [7] 0  | [0] char_valid, [1] has_char
//
// One transaction per cycle sustained while m_axis_tready is high; an accepted input passes
// through the character RAM read stage and then the output register to m_axis_tvalid.
// Pointers and shift flag update at accept; RAM content needs no clearing.
// Reset clears pointers, shift flag and all valid bits.
// A stalled m_axis holds the output register and the read stage, then s_axis_tready drops.
module scan_code_to_ascii_fifo #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
  input  logic       s_axis_tuser,   // [0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic [1:0] m_axis_tuser    // [0] char_valid, [1] has_char
);
  import sc2a_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] PtrLast = AW'(FIFO_DEPTH - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PtrLast) ? '0 : p + AW'(1);
  endfunction

  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic          shift_q, shift_d;

  logic          s1_v_q, s1_rd_q, s1_has_q;
  logic          s2_v_q, s2_rd_q, s2_has_q;
  logic [CharW-1:0] s2_char_q;
  logic          s1_adv, accept;

  logic [6:0]    key;
  logic          is_shift;
  logic [CharW-1:0] lut_char;
  logic          push, pop;
  logic [CharW-1:0] rdata;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s1_adv = s1_v_q && (!s2_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;

  assign key      = s_axis_tdata[6:0];
  assign is_shift = (key == KeyLshift) || (key == KeyRshift);
  assign lut_char = key_to_char(shift_q, key);

  always_comb begin
    push    = 1'b0;
    pop     = 1'b0;
    shift_d = shift_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    if (accept) begin
      if (s_axis_tuser == CmdRead) begin
        if (wp_q != rp_q) begin
          pop  = 1'b1;
          rp_d = ptr_inc(rp_q);
        end
      end else if (s_axis_tdata[7]) begin
        if (is_shift) shift_d = 1'b0;
      end else if (is_shift) begin
        shift_d = 1'b1;
      end else if (lut_char != '0) begin
        push = 1'b1;
        wp_d = ptr_inc(wp_q);
        if (wp_d == rp_q) rp_d = ptr_inc(rp_q);
      end
    end
  end

  sc2a_ram #(
    .WIDTH (CharW),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wp_q),
    .wdata_i (lut_char),
    .re_i    (pop),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      shift_q   <= 1'b0;
      s1_v_q    <= 1'b0;
      s1_rd_q   <= 1'b0;
      s1_has_q  <= 1'b0;
      s2_v_q    <= 1'b0;
      s2_rd_q   <= 1'b0;
      s2_has_q  <= 1'b0;
      s2_char_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      shift_q <= shift_d;
      if (accept) begin
        s1_v_q   <= 1'b1;
        s1_rd_q  <= pop;
        s1_has_q <= (wp_d != rp_d);
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q    <= 1'b1;
        s2_rd_q   <= s1_rd_q;
        s2_has_q  <= s1_has_q;
        s2_char_q <= s1_rd_q ? rdata : '0;
      end else if (m_axis_tready) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = s2_v_q;
  assign m_axis_tdata  = {1'b0, s2_char_q};
  assign m_axis_tuser  = {s2_has_q, s2_rd_q};

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q <= PtrLast) && (rp_q <= PtrLast))
    else $error("pointer out of range");

  a_valid_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[6:0] != '0)
    else $error("popped character is zero");

  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("character without char_valid");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_adv |-> !accept)
    else $error("accept while read stage is stalled");

endmodule
